>>> rtl/core/jfg_pkg.sv
// Shared types, constants and helper functions of the joint floor guard.
package jfg_pkg;

	localparam int NJ             = 7;
	localparam int NUM_ARMS_DEF   = 2;
	localparam int ANGLE_BITS_DEF = 16;

	// datapath and accumulator widths
	localparam int DW = 34;
	localparam int AW = 64;

	localparam int ANG_FULL = 23040;
	localparam int ANG_QUAD = 5760;

	localparam logic signed [DW-1:0] ONE    = 34'sd1073741824;
	localparam logic signed [DW-1:0] RAD    = 34'sd292818;
	localparam logic signed [DW-1:0] FULL_S = 34'sd23040;
	localparam logic signed [AW-1:0] HALF   = 64'sd536870912;

	localparam longint TWO32 = 64'sd4294967296;
	localparam logic signed [DW-1:0] RECIP_FULL = DW'(TWO32 / ANG_FULL);

	// floor(2^32/d) for the Horner divisors
	localparam longint M110 = TWO32 / 110;
	localparam longint M72  = TWO32 / 72;
	localparam longint M42  = TWO32 / 42;
	localparam longint M20  = TWO32 / 20;
	localparam longint M6   = TWO32 / 6;
	localparam longint M132 = TWO32 / 132;
	localparam longint M90  = TWO32 / 90;
	localparam longint M56  = TWO32 / 56;
	localparam longint M30  = TWO32 / 30;
	localparam longint M12  = TWO32 / 12;

	// fixed joint rotations and link offsets (Q16)
	localparam logic signed [1:0] ROT [NJ][3][3] = '{
		'{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}},
		'{'{1, 0, 0}, '{0, 0, -1}, '{0, 1, 0}},
		'{'{1, 0, 0}, '{0, 0, 1}, '{0, -1, 0}},
		'{'{-1, 0, 0}, '{0, 0, -1}, '{0, -1, 0}},
		'{'{-1, 0, 0}, '{0, 0, -1}, '{0, -1, 0}},
		'{'{0, -1, 0}, '{0, 0, -1}, '{1, 0, 0}},
		'{'{0, -1, 0}, '{0, 0, -1}, '{1, 0, 0}}
	};
	localparam logic signed [17:0] POS [NJ][3] = '{
		'{0, 0, 11436}, '{0, 0, 0}, '{0, 18809, 0}, '{1180, 0, 0},
		'{1180, -20578, 0}, '{0, 0, 0}, '{0, 0, 0}
	};

	typedef enum logic [2:0] {
		REG_Z_THR      = 3'd0,
		REG_TOOL_EN    = 3'd1,
		REG_TOOL_X     = 3'd2,
		REG_TOOL_Y     = 3'd3,
		REG_TOOL_Z     = 3'd4,
		REG_MOUNT_H    = 3'd5,
		REG_MOUNT_LAT  = 3'd6,
		REG_MOUNT_ROLL = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [18:0] z_thr;
		logic               tool_en;
		logic signed [17:0] tool_x;
		logic signed [17:0] tool_y;
		logic signed [17:0] tool_z;
		logic signed [18:0] mount_h;
		logic signed [17:0] mount_lat;
		logic signed [14:0] mount_roll;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic arm;
	} kin_ctl_t;

	typedef struct packed {
		logic done;
		logic ok;
	} kin_sts_t;

	// Horner divisor: sine stages 0..4, cosine stages 5..9
	function automatic logic signed [DW-1:0] div_d(input logic [3:0] i);
		logic signed [DW-1:0] d;
		unique case (i)
			4'd0: d = 34'sd110;
			4'd1: d = 34'sd72;
			4'd2: d = 34'sd42;
			4'd3: d = 34'sd20;
			4'd4: d = 34'sd6;
			4'd5: d = 34'sd132;
			4'd6: d = 34'sd90;
			4'd7: d = 34'sd56;
			4'd8: d = 34'sd30;
			4'd9: d = 34'sd12;
			default: d = 34'sd1;
		endcase
		return d;
	endfunction

	function automatic logic signed [DW-1:0] div_m(input logic [3:0] i);
		logic signed [DW-1:0] m;
		unique case (i)
			4'd0: m = DW'(M110);
			4'd1: m = DW'(M72);
			4'd2: m = DW'(M42);
			4'd3: m = DW'(M20);
			4'd4: m = DW'(M6);
			4'd5: m = DW'(M132);
			4'd6: m = DW'(M90);
			4'd7: m = DW'(M56);
			4'd8: m = DW'(M30);
			4'd9: m = DW'(M12);
			default: m = '0;
		endcase
		return m;
	endfunction

	// a in {-1,0,1} times v
	function automatic logic signed [DW-1:0] mterm(input logic signed [1:0] a,
		input logic signed [DW-1:0] v);
		logic signed [DW-1:0] r;
		priority if (a == 2'sd1) r = v;
		else if (a == -2'sd1) r = -v;
		else r = '0;
		return r;
	endfunction

endpackage

>>> rtl/core/jfg_mul.sv
// Registered signed multiplier shared by all arithmetic steps.
module jfg_mul #(
	parameter int W = 34
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

>>> rtl/core/jfg_kin.sv
// Sequencer for trig, transform chain and height check over one multiplier.
module jfg_kin #(
	parameter int ANGLE_BITS = jfg_pkg::ANGLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jfg_pkg::kin_ctl_t      ctl,
	input  jfg_pkg::cfg_t          cfg,
	input  logic signed [ANGLE_BITS-1:0] angle [jfg_pkg::NJ],
	output jfg_pkg::kin_sts_t      sts
);
	import jfg_pkg::*;

	// offset that makes any angle or negated roll non-negative
	localparam int OB = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
	localparam logic signed [DW-1:0] OFF =
		DW'(ANG_FULL * ((2**(OB-1) + ANG_FULL - 1) / ANG_FULL));

	typedef enum logic [24:0] {
		K_IDLE = 25'd1 << 0,
		K_ANG  = 25'd1 << 1,
		K_RED1 = 25'd1 << 2,
		K_RED2 = 25'd1 << 3,
		K_RED3 = 25'd1 << 4,
		K_RED4 = 25'd1 << 5,
		K_X1   = 25'd1 << 6,
		K_X2   = 25'd1 << 7,
		K_X3   = 25'd1 << 8,
		K_X4   = 25'd1 << 9,
		K_H1   = 25'd1 << 10,
		K_H2   = 25'd1 << 11,
		K_H3   = 25'd1 << 12,
		K_H4   = 25'd1 << 13,
		K_H5   = 25'd1 << 14,
		K_H6   = 25'd1 << 15,
		K_S1   = 25'd1 << 16,
		K_S2   = 25'd1 << 17,
		K_QM   = 25'd1 << 18,
		K_MM1  = 25'd1 << 19,
		K_MM2  = 25'd1 << 20,
		K_CHK  = 25'd1 << 21,
		K_TL1  = 25'd1 << 22,
		K_TL2  = 25'd1 << 23,
		K_DONE = 25'd1 << 24
	} kst_t;

	kst_t state_q;
	logic [2:0] idx_q, cnt_q;
	logic       cosph_q, ok_q;
	logic [1:0] ri_q, col_q, k_q, quad_q;
	logic [12:0] f_q;
	logic signed [DW-1:0] u_q, q_q, n_q, x_q, x2_q, t_q, sv_q, cv_q, s_q, c_q;
	logic signed [DW-1:0] r_q [3][3];
	logic signed [DW-1:0] p_q [3];
	logic signed [DW-1:0] nr_q [3];
	logic signed [AW-1:0] acc_q;

	logic signed [DW-1:0]   mul_a, mul_b;
	logic signed [2*DW-1:0] prod;

	jfg_mul #(.W(DW)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	logic [2:0] jx;
	logic [3:0] di;
	logic signed [DW-1:0] ang_ext, roll_ext, thr_ext, dd;
	logic signed [DW-1:0] r0, r1, hr, qf, mm_b, toff, ms, mc, rnd;
	logic signed [AW-1:0] acc_n;
	logic [1:0] quad_n;
	logic [12:0] f_n;

	always_comb begin
		jx       = idx_q - 3'd1;
		di       = cosph_q ? (4'(cnt_q) + 4'd5) : 4'(cnt_q);
		dd       = div_d(di);
		thr_ext  = DW'(cfg.z_thr);
		roll_ext = DW'(cfg.mount_roll);
		if (ctl.arm)
			roll_ext = -roll_ext;
		ang_ext  = (idx_q == 3'd0) ? roll_ext : DW'(angle[jx]);

		// angle reduction: remainder fix, quadrant and offset in quadrant
		r0 = u_q - prod[DW-1:0];
		r1 = (r0 >= FULL_S) ? (r0 - FULL_S) : r0;
		priority if (r1 >= 34'sd17280) begin
			quad_n = 2'd3; f_n = 13'(r1 - 34'sd17280);
		end else if (r1 >= 34'sd11520) begin
			quad_n = 2'd2; f_n = 13'(r1 - 34'sd11520);
		end else if (r1 >= 34'sd5760) begin
			quad_n = 2'd1; f_n = 13'(r1 - 34'sd5760);
		end else begin
			quad_n = 2'd0; f_n = 13'(r1);
		end

		// truncating quotient correction
		hr = n_q - prod[DW-1:0];
		qf = (hr >= dd) ? (q_q + 34'sd1) : q_q;

		unique case (quad_q)
			2'd0: begin ms = sv_q;  mc = cv_q;  end
			2'd1: begin ms = cv_q;  mc = -sv_q; end
			2'd2: begin ms = -sv_q; mc = -cv_q; end
			default: begin ms = -cv_q; mc = sv_q; end
		endcase

		unique case (col_q)
			2'd0: mm_b = mterm(ROT[jx][k_q][0], c_q) + mterm(ROT[jx][k_q][1], s_q);
			2'd1: mm_b = mterm(ROT[jx][k_q][1], c_q) - mterm(ROT[jx][k_q][0], s_q);
			2'd2: mm_b = mterm(ROT[jx][k_q][2], ONE);
			default: mm_b = DW'(POS[jx][k_q]);
		endcase

		unique case (k_q)
			2'd0: toff = DW'(cfg.tool_x);
			2'd1: toff = DW'(cfg.tool_y);
			default: toff = DW'(cfg.tool_z);
		endcase

		acc_n = acc_q + prod[AW-1:0];
		rnd   = DW'((acc_n + HALF) >>> 30);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			K_RED1: begin mul_a = u_q; mul_b = RECIP_FULL; end
			K_RED3: begin mul_a = q_q; mul_b = FULL_S; end
			K_X1:   begin mul_a = DW'(f_q); mul_b = RAD; end
			K_X3:   begin mul_a = x_q; mul_b = x_q; end
			K_H1:   begin mul_a = x2_q; mul_b = t_q; end
			K_H3:   begin mul_a = n_q; mul_b = div_m(di); end
			K_H5:   begin mul_a = q_q; mul_b = dd; end
			K_S1:   begin mul_a = x_q; mul_b = t_q; end
			K_MM1:  begin mul_a = r_q[ri_q][k_q]; mul_b = mm_b; end
			K_TL1:  begin mul_a = r_q[2][k_q]; mul_b = toff; end
			default: ;
		endcase
	end

	assign sts.done = (state_q == K_DONE);
	assign sts.ok   = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			cosph_q <= 1'b0;
			ok_q    <= 1'b1;
			ri_q    <= '0;
			col_q   <= '0;
			k_q     <= '0;
			quad_q  <= '0;
			f_q     <= '0;
			u_q     <= '0;
			q_q     <= '0;
			n_q     <= '0;
			x_q     <= '0;
			x2_q    <= '0;
			t_q     <= '0;
			sv_q    <= '0;
			cv_q    <= '0;
			s_q     <= '0;
			c_q     <= '0;
			acc_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				p_q[i]  <= '0;
				nr_q[i] <= '0;
				for (int j = 0; j < 3; j++)
					r_q[i][j] <= '0;
			end
		end else begin
			unique case (state_q)
				K_IDLE: if (ctl.start) begin
					idx_q   <= '0;
					ok_q    <= 1'b1;
					state_q <= K_ANG;
				end
				K_ANG: begin
					u_q     <= ang_ext + OFF;
					state_q <= K_RED1;
				end
				K_RED1: state_q <= K_RED2;
				K_RED2: begin
					q_q     <= DW'(prod >>> 32);
					state_q <= K_RED3;
				end
				K_RED3: state_q <= K_RED4;
				K_RED4: begin
					quad_q  <= quad_n;
					f_q     <= f_n;
					state_q <= K_X1;
				end
				K_X1: state_q <= K_X2;
				K_X2: begin
					x_q     <= prod[DW-1:0];
					state_q <= K_X3;
				end
				K_X3: state_q <= K_X4;
				K_X4: begin
					x2_q    <= DW'(prod >>> 30);
					t_q     <= ONE;
					cnt_q   <= '0;
					cosph_q <= 1'b0;
					state_q <= K_H1;
				end
				K_H1: state_q <= K_H2;
				K_H2: begin
					n_q <= DW'(prod >>> 30);
					if (cosph_q && cnt_q == 3'd5) begin
						// last cosine stage halves
						cv_q    <= ONE - DW'(prod >>> 31);
						state_q <= K_QM;
					end else begin
						state_q <= K_H3;
					end
				end
				K_H3: state_q <= K_H4;
				K_H4: begin
					q_q     <= DW'(prod >>> 32);
					state_q <= K_H5;
				end
				K_H5: state_q <= K_H6;
				K_H6: begin
					t_q   <= ONE - qf;
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4 && !cosph_q)
						state_q <= K_S1;
					else
						state_q <= K_H1;
				end
				K_S1: state_q <= K_S2;
				K_S2: begin
					sv_q    <= DW'(prod >>> 30);
					t_q     <= ONE;
					cnt_q   <= '0;
					cosph_q <= 1'b1;
					state_q <= K_H1;
				end
				K_QM: begin
					s_q <= ms;
					c_q <= mc;
					if (idx_q == 3'd0) begin
						// mount: roll about x, lateral and height offset
						r_q[0][0] <= ONE; r_q[0][1] <= '0; r_q[0][2] <= '0;
						r_q[1][0] <= '0;  r_q[1][1] <= mc; r_q[1][2] <= -ms;
						r_q[2][0] <= '0;  r_q[2][1] <= ms; r_q[2][2] <= mc;
						p_q[0] <= '0;
						p_q[1] <= ctl.arm ? -DW'(cfg.mount_lat) : DW'(cfg.mount_lat);
						p_q[2] <= DW'(cfg.mount_h);
						idx_q  <= 3'd1;
						state_q <= K_ANG;
					end else begin
						ri_q    <= '0;
						col_q   <= '0;
						k_q     <= '0;
						acc_q   <= '0;
						state_q <= K_MM1;
					end
				end
				K_MM1: state_q <= K_MM2;
				K_MM2: begin
					if (k_q != 2'd2) begin
						acc_q   <= acc_n;
						k_q     <= k_q + 2'd1;
						state_q <= K_MM1;
					end else begin
						acc_q <= '0;
						k_q   <= '0;
						if (col_q != 2'd3) begin
							nr_q[col_q] <= rnd;
							col_q       <= col_q + 2'd1;
							state_q     <= K_MM1;
						end else begin
							p_q[ri_q] <= p_q[ri_q] + rnd;
							for (int j = 0; j < 3; j++)
								r_q[ri_q][j] <= nr_q[j];
							col_q <= '0;
							if (ri_q != 2'd2) begin
								ri_q    <= ri_q + 2'd1;
								state_q <= K_MM1;
							end else begin
								state_q <= K_CHK;
							end
						end
					end
				end
				K_CHK: begin
					if (p_q[2] < thr_ext)
						ok_q <= 1'b0;
					if (idx_q != 3'(NJ)) begin
						idx_q   <= idx_q + 3'd1;
						state_q <= K_ANG;
					end else if (cfg.tool_en) begin
						k_q     <= '0;
						acc_q   <= '0;
						state_q <= K_TL1;
					end else begin
						state_q <= K_DONE;
					end
				end
				K_TL1: state_q <= K_TL2;
				K_TL2: begin
					if (k_q != 2'd2) begin
						acc_q   <= acc_n;
						k_q     <= k_q + 2'd1;
						state_q <= K_TL1;
					end else begin
						if (rnd + p_q[2] < thr_ext)
							ok_q <= 1'b0;
						state_q <= K_DONE;
					end
				end
				K_DONE: state_q <= K_IDLE;
				default: state_q <= K_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/joint_fk_floor_guard.sv
// Top level: stream ports, registers, safe pose store and result register.
// Floor guard for seven-joint arms, one command at a time.
// Slave stream (s_*) takes a command: tuser says check or seed and which arm,
// tdata carries the seven joint angles. Master stream (m_*) returns one
// result per command: tuser is the passed flag, tdata the angles sent on and
// the hold count. The cfg_* channel writes one register per transaction and
// is always ready; write it only while no command is in flight.
// A check command runs eight sine/cosine evaluations and seven 3x3 transform
// products, plus the tool tip height when the tool tip is on, all on one shared
// 34x34 registered multiplier. A seed command skips them and goes straight to
// the result register.
// s_tready is high only while no command is in flight. A finished result
// sits in the output register until m_tready takes it; the next command may
// be accepted meanwhile, but its result waits until the register is free.
// Reset clears all arms' safe poses and hold counts, puts the registers at
// their reset values and empties the output register.
module joint_fk_floor_guard #(
	parameter int NUM_ARMS   = jfg_pkg::NUM_ARMS_DEF,
	parameter int ANGLE_BITS = jfg_pkg::ANGLE_BITS_DEF,
	localparam int ITW = ((jfg_pkg::NJ * ANGLE_BITS + 7) / 8) * 8,
	localparam int OTW = ((jfg_pkg::NJ * ANGLE_BITS + 16 + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [ITW-1:0] s_tdata,  // angle_in_0 .. angle_in_6
	input  logic [1:0]     s_tuser,  // operation, arm_index
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [OTW-1:0] m_tdata,  // angle_out_0 .. angle_out_6, hold_count
	output logic [0:0]     m_tuser,  // passed
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [18:0]    cfg_data
);
	import jfg_pkg::*;

	localparam int HB = NJ * ANGLE_BITS;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_BUSY = 3'b010,
		T_RES  = 3'b100
	} tst_t;

	tst_t  state_q;
	cfg_t  cfg_q;
	logic  op_q, arm_q, pass_q;
	logic signed [ANGLE_BITS-1:0] ang_q [NJ];
	logic signed [ANGLE_BITS-1:0] pose_q [NUM_ARMS][NJ];
	logic [15:0] streak_q [NUM_ARMS];
	logic        m_tvalid_q;
	logic [OTW-1:0] m_tdata_q;
	logic        m_tuser_q;

	kin_ctl_t kctl;
	kin_sts_t ksts;

	logic accept, arm_in, slot_free;
	logic [15:0] streak_n;
	logic [OTW-1:0] res_data;

	assign s_tready  = (state_q == T_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign arm_in    = (NUM_ARMS > 1) ? s_tuser[1] : 1'b0;
	assign slot_free = !m_tvalid_q || m_tready;
	assign streak_n  = (streak_q[arm_q] == 16'hFFFF) ? 16'hFFFF : streak_q[arm_q] + 16'd1;

	// start on the accepting edge; arm comes from the captured command
	assign kctl.start = accept && !s_tuser[0];
	assign kctl.arm   = arm_q;

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// result payload: command angles when passed, else the held pose
	always_comb begin
		res_data = '0;
		for (int j = 0; j < NJ; j++)
			res_data[j*ANGLE_BITS +: ANGLE_BITS] = pass_q ? ang_q[j] : pose_q[arm_q][j];
		res_data[HB +: 16] = pass_q ? 16'd0 : streak_n;
	end

	jfg_kin #(.ANGLE_BITS(ANGLE_BITS)) u_kin (
		.clk(clk), .arst_n(arst_n), .ctl(kctl), .cfg(cfg_q), .angle(ang_q), .sts(ksts)
	);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.z_thr      <= '0;
			cfg_q.tool_en    <= 1'b0;
			cfg_q.tool_x     <= '0;
			cfg_q.tool_y     <= '0;
			cfg_q.tool_z     <= '0;
			cfg_q.mount_h    <= 19'sd23718;
			cfg_q.mount_lat  <= 18'sd2425;
			cfg_q.mount_roll <= -15'sd5760;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_Z_THR:      cfg_q.z_thr      <= cfg_data;
				REG_TOOL_EN:    cfg_q.tool_en    <= cfg_data[0];
				REG_TOOL_X:     cfg_q.tool_x     <= cfg_data[17:0];
				REG_TOOL_Y:     cfg_q.tool_y     <= cfg_data[17:0];
				REG_TOOL_Z:     cfg_q.tool_z     <= cfg_data[17:0];
				REG_MOUNT_H:    cfg_q.mount_h    <= cfg_data;
				REG_MOUNT_LAT:  cfg_q.mount_lat  <= cfg_data[17:0];
				REG_MOUNT_ROLL: cfg_q.mount_roll <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// command flow, pose store and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			op_q       <= 1'b0;
			arm_q      <= 1'b0;
			pass_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			for (int j = 0; j < NJ; j++)
				ang_q[j] <= '0;
			for (int a = 0; a < NUM_ARMS; a++) begin
				streak_q[a] <= '0;
				for (int j = 0; j < NJ; j++)
					pose_q[a][j] <= '0;
			end
		end else begin
			if (state_q == T_RES && slot_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: if (accept) begin
					op_q  <= s_tuser[0];
					arm_q <= arm_in;
					for (int j = 0; j < NJ; j++)
						ang_q[j] <= s_tdata[j*ANGLE_BITS +: ANGLE_BITS];
					pass_q  <= 1'b1;
					state_q <= s_tuser[0] ? T_RES : T_BUSY;
				end
				T_BUSY: if (ksts.done) begin
					pass_q  <= ksts.ok;
					state_q <= T_RES;
				end
				T_RES: if (slot_free) begin
					m_tuser_q <= pass_q;
					m_tdata_q <= res_data;
					if (pass_q) begin
						// safe or seeded: store as safe pose
						for (int j = 0; j < NJ; j++)
							pose_q[arm_q][j] <= ang_q[j];
						streak_q[arm_q] <= '0;
					end else begin
						// unsafe: hold the last safe pose
						streak_q[arm_q] <= streak_n;
					end
					state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	logic unused_op;
	assign unused_op = op_q;
endmodule

>>> rtl/core/jfg_checker.sv
// Port-level assertions for the floor guard and their bind to the top level.
module jfg_checker #(
	parameter int ANGLE_BITS = jfg_pkg::ANGLE_BITS_DEF,
	localparam int OTW = ((jfg_pkg::NJ * ANGLE_BITS + 16 + 7) / 8) * 8,
	localparam int HB  = jfg_pkg::NJ * ANGLE_BITS
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [OTW-1:0] m_tdata,
	input logic [0:0]     m_tuser
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// one command in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command accepted while busy");

	// passed result clears the hold count
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[HB+15:HB] == 16'd0)
		else $error("passed result with nonzero hold count");

	// held result counts at least one violation
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[HB+15:HB] != 16'd0)
		else $error("held result with zero hold count");
endmodule

bind joint_fk_floor_guard jfg_checker #(.ANGLE_BITS(ANGLE_BITS)) u_jfg_checker (.*);
